FILE: rtl/sgdl_pkg.sv
// Package: constants and types shared by the stereo glide delay line.
`timescale 1ns / 1ps
package sgdl_pkg;
  localparam int unsigned DefDepth = 16384;
  localparam int unsigned DefFrac  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEND    = 3'd0,
    CFG_FB      = 3'd1,
    CFG_RATIO   = 3'd2,
    CFG_SPMS    = 3'd3,
    CFG_ADJ     = 3'd4,
    CFG_SMOOTH  = 3'd5,
    CFG_OFF_L   = 3'd6,
    CFG_OFF_R   = 3'd7
  } cfg_idx_e;

  // Clear sweep, then per word: speed update and two reads per tap, one write.
  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_SPDL  = 10'b0000000100,
    ST_SPDR  = 10'b0000001000,
    ST_RL0   = 10'b0000010000,
    ST_RL1   = 10'b0000100000,
    ST_RR0   = 10'b0001000000,
    ST_RR1   = 10'b0010000000,
    ST_WR    = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;
endpackage

FILE: rtl/sgdl_tap_speed.sv
// Tap speed update: error to target speed, clamp, smoothing step (two stages).
`timescale 1ns / 1ps
module sgdl_tap_speed import sgdl_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned FRAC  = DefFrac
) (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic [$clog2(DEPTH)-1:0]    wptr_i,
  input  logic [$clog2(DEPTH)+FRAC-1:0] pos_i,
  input  logic signed [31:0]          target_i,  // Q24.8 samples
  input  logic [15:0]                 adjust_i,
  input  logic [15:0]                 smooth_i,
  input  logic [FRAC+1:0]             speed_i,
  output logic [FRAC+1:0]             speed_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + FRAC;
  localparam int unsigned EW = PW + 26;
  localparam int unsigned SW = FRAC + 2;
  localparam logic [SW-1:0] One = SW'(1) << FRAC;
  localparam logic [SW-1:0] SpdLo = SW'(((3 << FRAC) + 5) / 10);
  localparam logic [SW-1:0] SpdHi = SW'(3) << FRAC;

  logic [PW-1:0] cur;
  logic signed [EW-1:0] tgt_ext, err;
  logic [EW-1:0] mag;
  logic [EW+15:0] prod;
  logic [EW-1:0] offs;
  logic [SW+1:0] off4;
  logic signed [SW+2:0] tgt;
  logic [SW-1:0] tgt_q_d, tgt_q_q;
  logic signed [SW+1:0] gap;
  logic signed [SW+18:0] step_full;
  logic signed [SW+2:0] step;

  assign cur = {wptr_i, {FRAC{1'b0}}} - pos_i;
  always_comb begin
    if (FRAC >= 8) tgt_ext = EW'(target_i) <<< (FRAC - 8);
    else tgt_ext = EW'(target_i);
    err  = $signed({{(EW-PW){1'b0}}, cur}) - tgt_ext;
    mag  = err[EW-1] ? EW'(-err) : EW'(err);
    prod = mag * adjust_i;
    offs = EW'(prod >> 16);
    off4 = (offs > EW'(4 * One)) ? (SW+2)'(4 * One) : offs[SW+1:0];
    tgt  = err[EW-1] ? $signed({2'b0, One}) - $signed({1'b0, off4})
                     : $signed({2'b0, One}) + $signed({1'b0, off4});
    if (tgt < $signed({3'b0, SpdLo})) tgt_q_d = SpdLo;
    else if (tgt > $signed({3'b0, SpdHi})) tgt_q_d = SpdHi;
    else tgt_q_d = tgt[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) tgt_q_q <= tgt_q_d;
  end

  always_comb begin
    gap = $signed({2'b0, tgt_q_q}) - $signed({2'b0, speed_i});
    step_full = gap * $signed({1'b0, smooth_i});
    step = (SW+3)'(step_full >>> 16);
    speed_o = SW'($signed({3'b0, speed_i}) + step);
  end
endmodule

FILE: rtl/stereo_glide_delay_line.sv
// Top level: stereo glide delay line with a single-port sample store.
// Each word passes through the accept state, the speed update states SPDL and
// SPDR, four reads of the sample store, one write and the result load, all on
// the single port of the sample store. The next word is taken while a result
// still waits; only the result load waits for the output to drain. After reset
// a clearing pass writes zero to every entry while no word is accepted;
// configuration writes are taken at any time. in_stall_o is high during the
// clearing pass and while a word is in work.
`timescale 1ns / 1ps
module stereo_glide_delay_line import sgdl_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DefDepth,
  parameter int unsigned FRAC_BITS    = DefFrac
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  in_left_i,
  input  logic [11:0]         delay_time_ms_i,
  input  logic [9:0]          spread_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  out_left_o,
  output logic signed [15:0]  out_right_o
);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned PW = AW + FRAC_BITS;
  localparam int unsigned SW = FRAC_BITS + 2;
  localparam logic [SW-1:0] One = SW'(1) << FRAC_BITS;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [14:0] send_q, fb_q;
  logic [4:0] ratio_q;
  logic [15:0] spms_q, adj_q, smooth_q;
  logic [AW-1:0] wptr_q;
  logic [PW-1:0] pos_l_q, pos_r_q;
  logic [SW-1:0] spd_l_q, spd_r_q;
  logic [3:0] wph_q, rph_l_q, rph_r_q;
  logic signed [15:0] held_l_q, held_r_q;
  logic signed [15:0] x_q, s0_q;
  logic signed [31:0] tgt_l_q, tgt_r_q;
  logic rd_l_q, rd_r_q, wr_q;
  logic out_valid_q;
  logic signed [15:0] out_l_q, out_r_q;

  logic [15:0] mem [BUFFER_DEPTH];
  logic signed [15:0] rdata_q;
  logic [AW-1:0] addr;
  logic we;
  logic [15:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  // Effective ratio 1..16 and action flags.
  logic [4:0] r_eff;
  assign r_eff = (ratio_q == 5'd0) ? 5'd1 : (ratio_q > 5'd16) ? 5'd16 : ratio_q;
  function automatic logic act(input logic [3:0] ph, input logic [4:0] r);
    act = ({1'b0, ph} + 5'd1) >= r;
  endfunction

  logic accept;
  logic out_free;
  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared speed unit: target latched in SPDL (left) and SPDR (right),
  // speeds written back in the state after each (SPDR and RL0).
  logic spd_start;
  logic [PW-1:0] su_pos;
  logic signed [31:0] su_tgt;
  logic [SW-1:0] su_spd, su_new;
  assign spd_start = (state_q == ST_SPDL) || (state_q == ST_SPDR);
  always_comb begin
    if (state_q == ST_SPDL) begin
      su_pos = pos_l_q; su_tgt = tgt_l_q;
    end else begin
      su_pos = pos_r_q; su_tgt = tgt_r_q;
    end
    su_spd = (state_q == ST_RL0) ? spd_r_q : spd_l_q;
  end
  sgdl_tap_speed #(.DEPTH(BUFFER_DEPTH), .FRAC(FRAC_BITS)) u_speed (
    .clk_i, .start_i(spd_start), .wptr_i(wptr_q), .pos_i(su_pos),
    .target_i(su_tgt), .adjust_i(adj_q), .smooth_i(smooth_q),
    .speed_i(su_spd), .speed_o(su_new)
  );

  // Interpolation of the word just read against s0.
  logic [FRAC_BITS-1:0] frac;
  logic signed [16:0] diff;
  logic signed [FRAC_BITS+17:0] dprod;
  logic signed [15:0] interp;
  always_comb begin
    frac = (state_q == ST_RL1) ? pos_l_q[FRAC_BITS-1:0] : pos_r_q[FRAC_BITS-1:0];
    diff = {rdata_q[15], rdata_q} - {s0_q[15], s0_q};
    dprod = diff * $signed({1'b0, frac});
    interp = 16'(s0_q + 16'(dprod >>> FRAC_BITS));
  end

  // Write value.
  logic signed [33:0] acc;
  logic signed [33:0] accs;
  always_comb begin
    acc = 34'($signed(x_q) * $signed({1'b0, send_q})) * 34'sd2
        + 34'(($signed({held_l_q[15], held_l_q}) + $signed({held_r_q[15], held_r_q}))
              * $signed({1'b0, fb_q}));
    accs = acc >>> 16;
    if (accs > 34'sd32767) wdata = 16'h7fff;
    else if (accs < -34'sd32768) wdata = 16'h8000;
    else wdata = accs[15:0];
    if (state_q == ST_CLEAR) wdata = 16'h0000;
  end

  logic [AW-1:0] il, ir;
  assign il = pos_l_q[PW-1:FRAC_BITS];
  assign ir = pos_r_q[PW-1:FRAC_BITS];
  always_comb begin
    we = 1'b0;
    addr = wptr_q;
    case (state_q)
      ST_CLEAR: begin we = 1'b1; addr = clr_q; end
      ST_SPDR:  addr = il;
      ST_RL0:   addr = il + AW'(1);
      ST_RL1:   addr = ir;
      ST_RR0:   addr = ir + AW'(1);
      ST_WR:    begin we = wr_q; addr = wptr_q; end
      default:  addr = wptr_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(BUFFER_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_SPDL;
      ST_SPDL:  state_d = ST_SPDR;
      ST_SPDR:  state_d = ST_RL0;
      ST_RL0:   state_d = ST_RL1;
      ST_RL1:   state_d = ST_RR0;
      ST_RR0:   state_d = ST_RR1;
      ST_RR1:   state_d = ST_WR;
      ST_WR:    state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic [AW-1:0] offs;
  assign offs = AW'(cfg_data_i[13:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0;
      send_q <= 15'd16384; fb_q <= 15'd13107; ratio_q <= 5'd1;
      spms_q <= 16'd11290; adj_q <= 16'd328; smooth_q <= 16'd655;
      wptr_q <= '0;
      pos_l_q <= {AW'(BUFFER_DEPTH - 4410), {FRAC_BITS{1'b0}}};
      pos_r_q <= {AW'(BUFFER_DEPTH - 4410), {FRAC_BITS{1'b0}}};
      spd_l_q <= One; spd_r_q <= One;
      wph_q <= '0; rph_l_q <= '0; rph_r_q <= '0;
      held_l_q <= '0; held_r_q <= '0;
      out_valid_q <= 1'b0;
      rd_l_q <= 1'b0; rd_r_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (accept) begin
        rd_l_q <= act(rph_l_q, r_eff);
        rph_l_q <= act(rph_l_q, r_eff) ? 4'd0 : rph_l_q + 4'd1;
        rd_r_q <= act(rph_r_q, r_eff);
        rph_r_q <= act(rph_r_q, r_eff) ? 4'd0 : rph_r_q + 4'd1;
        wr_q <= act(wph_q, r_eff);
        wph_q <= act(wph_q, r_eff) ? 4'd0 : wph_q + 4'd1;
      end
      case (state_q)
        ST_SPDR: spd_l_q <= su_new;
        ST_RL0:  spd_r_q <= su_new;
        ST_RL1: if (rd_l_q) begin
          held_l_q <= interp; pos_l_q <= pos_l_q + PW'(spd_l_q);
        end
        ST_RR1: if (rd_r_q) begin
          held_r_q <= interp; pos_r_q <= pos_r_q + PW'(spd_r_q);
        end
        ST_WR: if (wr_q) wptr_q <= wptr_q + AW'(1);
        default: ;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEND:   send_q <= cfg_data_i[14:0];
          CFG_FB:     fb_q <= cfg_data_i[14:0];
          CFG_RATIO:  ratio_q <= cfg_data_i[4:0];
          CFG_SPMS:   spms_q <= cfg_data_i;
          CFG_ADJ:    adj_q <= cfg_data_i;
          CFG_SMOOTH: smooth_q <= cfg_data_i;
          CFG_OFF_L:  pos_l_q <= {AW'(0) - offs, {FRAC_BITS{1'b0}}};
          CFG_OFF_R:  pos_r_q <= {AW'(0) - offs, {FRAC_BITS{1'b0}}};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= in_left_i;
      tgt_l_q <= ($signed({20'b0, delay_time_ms_i}) - $signed({22'b0, spread_ms_i}))
                 * $signed({16'b0, spms_q});
      tgt_r_q <= ($signed({20'b0, delay_time_ms_i}) + $signed({22'b0, spread_ms_i}))
                 * $signed({16'b0, spms_q});
    end
    if (state_q == ST_RL0 || state_q == ST_RR0) s0_q <= rdata_q;
    if (state_q == ST_OUT && out_free) begin
      out_l_q <= held_l_q; out_r_q <= held_r_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
endmodule

FILE: tb/sv/stereo_glide_delay_line_tb.sv
// Testbench: random and directed words through the delay line, checked against a local predictor.
`timescale 1ns / 1ps
module stereo_glide_delay_line_tb;
  import sgdl_pkg::*;

  localparam int unsigned Depth = DefDepth;
  localparam int unsigned Frac  = DefFrac;
  localparam longint Span  = longint'(Depth) << Frac;
  localparam longint OneSp = longint'(1) << Frac;
  localparam longint SpLo  = ((longint'(3) << Frac) + 5) / 10;
  localparam longint SpHi  = longint'(3) << Frac;

  typedef struct packed {
    logic signed [15:0] left;
    logic [11:0]        dly;
    logic [9:0]         spr;
  } word_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] r;
  } pair_t;

  typedef struct {
    longint pos;
    longint speed;
    int     phase;
    longint held;
  } tap_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] in_left, out_left, out_right;
  logic [11:0] dly_in;
  logic [9:0] spr_in;

  stereo_glide_delay_line u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_left_i(in_left), .delay_time_ms_i(dly_in), .spread_ms_i(spr_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_left_o(out_left), .out_right_o(out_right)
  );

  // predictor state
  logic [15:0] line_mem [Depth];
  int     wr_ptr, wr_phase;
  tap_t   tl, tr;
  longint send_lvl, fb_gain, ratio, spms, adj, smooth;

  word_t  pending_words[$];
  pair_t  expected_pairs[$];
  int     errors;
  int     words_checked;
  bit     hold_off;

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint start_at(longint off);
    return ((longint'(Depth) - (off % Depth)) % Depth) << Frac;
  endfunction

  function automatic bit phase_hit(ref int ph, input longint r);
    if (ph + 1 >= r) begin
      ph = 0;
      return 1;
    end
    ph = (ph + 1) & 15;
    return 0;
  endfunction

  task automatic glide_tap(ref tap_t t, input longint tgt8, input longint r);
    longint cur, err, mag, off, tgt, p, fr, s0, s1;
    int i0, i1;
    cur = ((longint'(wr_ptr) << Frac) + Span - t.pos) % Span;
    err = cur - tgt8 * (longint'(1) << (Frac - 8));
    mag = err < 0 ? -err : err;
    off = (mag * adj) >> 16;
    if (off > 4 * OneSp) off = 4 * OneSp;
    tgt = err < 0 ? OneSp - off : OneSp + off;
    if (tgt < SpLo) tgt = SpLo;
    if (tgt > SpHi) tgt = SpHi;
    t.speed += floor_shr((tgt - t.speed) * smooth, 16);
    if (phase_hit(t.phase, r)) begin
      p  = t.pos % Span;
      i0 = int'((p >> Frac) % Depth);
      i1 = (i0 + 1) % Depth;
      fr = p & ((longint'(1) << Frac) - 1);
      s0 = longint'($signed(line_mem[i0]));
      s1 = longint'($signed(line_mem[i1]));
      t.held = s0 + floor_shr((s1 - s0) * fr, Frac);
      t.pos = (p + t.speed) % Span;
    end
  endtask

  task automatic predict_pair(input word_t w);
    longint x, d, s, r, acc;
    pair_t res;
    x = longint'(w.left);
    d = longint'(w.dly);
    s = longint'(w.spr);
    r = ratio;
    if (r == 0) r = 1;
    if (r > 16) r = 16;
    glide_tap(tl, (d - s) * spms, r);
    glide_tap(tr, (d + s) * spms, r);
    if (phase_hit(wr_phase, r)) begin
      acc = floor_shr(2 * x * send_lvl + (tl.held + tr.held) * fb_gain, 16);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      line_mem[wr_ptr] = acc[15:0];
      wr_ptr = (wr_ptr + 1) % Depth;
    end
    res.l = tl.held[15:0];
    res.r = tr.held[15:0];
    expected_pairs.push_back(res);
  endtask

  task automatic shadow_cfg(input cfg_idx_e idx, input logic [15:0] v);
    case (idx)
      CFG_SEND:   send_lvl = v & 16'h7fff;
      CFG_FB:     fb_gain  = v & 16'h7fff;
      CFG_RATIO:  ratio    = v & 16'h1f;
      CFG_SPMS:   spms     = v;
      CFG_ADJ:    adj      = v;
      CFG_SMOOTH: smooth   = v;
      CFG_OFF_L:  tl.pos   = start_at(v & 16'h3fff);
      CFG_OFF_R:  tr.pos   = start_at(v & 16'h3fff);
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("word %0d: %s got %h want %h", words_checked, what, got, want);
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // stall as seen at the rising edge just before the driver's falling edge
  logic in_stall_q;
  always @(posedge clk) in_stall_q <= in_stall;

  // driver
  int gap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      gap <= 0;
    end else begin
      if (in_valid && in_stall_q) begin
        // hold payload
      end else if (gap > 0 || hold_off) begin
        in_valid <= 0;
        if (gap > 0) gap <= gap - 1;
      end else if (pending_words.size() > 0) begin
        word_t w;
        w = pending_words.pop_front();
        predict_pair(w);
        in_valid <= 1;
        in_left <= w.left;
        dly_in <= w.dly;
        spr_in <= w.spr;
        gap <= pick_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // receiver stall
  int ostall_n;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 0;
      ostall_n <= 0;
    end else if (ostall_n > 0) begin
      out_stall <= 1;
      ostall_n <= ostall_n - 1;
    end else begin
      out_stall <= 0;
      if ($urandom_range(0, 9) < 3) ostall_n <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pair_t e;
      if (expected_pairs.size() == 0) begin
        report("unexpected result word, out_left", out_left, 16'h0000);
      end else begin
        e = expected_pairs.pop_front();
        if (out_left !== e.l) report("out_left", out_left, e.l);
        if (out_right !== e.r) report("out_right", out_right, e.r);
      end
      words_checked++;
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    shadow_cfg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_pairs.size() > 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    word_t w;
    w.left = 16'($urandom());
    w.dly  = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 700));
    w.spr  = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 200));
    return w;
  endfunction

  task automatic rand_cfg();
    cfg_write(CFG_SEND, 16'($urandom_range(0, 32767)));
    cfg_write(CFG_FB, 16'($urandom_range(0, 32767)));
    cfg_write(CFG_RATIO, 16'($urandom_range(0, 31)));
    cfg_write(CFG_SPMS, 16'($urandom()));
    cfg_write(CFG_ADJ, 16'($urandom()));
    cfg_write(CFG_SMOOTH, 16'($urandom()));
    cfg_write(CFG_OFF_L, 16'($urandom_range(0, 16383)));
    cfg_write(CFG_OFF_R, 16'($urandom_range(0, 16383)));
  endtask

  initial begin
    word_t w;
    errors = 0;
    words_checked = 0;
    hold_off = 0;
    cfg_we = 0;
    cfg_idx = CFG_SEND;
    cfg_data = 0;
    in_left = 0;
    dly_in = 0;
    spr_in = 0;
    foreach (line_mem[i]) line_mem[i] = 0;
    wr_ptr = 0;
    wr_phase = 0;
    send_lvl = 16384; fb_gain = 13107; ratio = 1; spms = 11290; adj = 328; smooth = 655;
    tl = '{start_at(4410), OneSp, 0, 0};
    tr = tl;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes at reset settings, including negative left target
    w = '{16'sh7fff, 12'd0, 10'd1023};   pending_words.push_back(w);
    w = '{-16'sh8000, 12'd4095, 10'd0};  pending_words.push_back(w);
    w = '{16'sh0000, 12'd4095, 10'd1023}; pending_words.push_back(w);
    w = '{16'sh7fff, 12'd100, 10'd0};    pending_words.push_back(w);
    w = '{-16'sh8000, 12'd0, 10'd0};     pending_words.push_back(w);
    drain();
    // extremes: full gains, short taps so written words are read back, left offset zero, right offset 3
    cfg_write(CFG_SEND, 16'h7fff);
    cfg_write(CFG_FB, 16'h7fff);
    cfg_write(CFG_SPMS, 16'hffff);
    cfg_write(CFG_ADJ, 16'hffff);
    cfg_write(CFG_SMOOTH, 16'hffff);
    cfg_write(CFG_OFF_L, 16'd0);
    cfg_write(CFG_OFF_R, 16'd3);
    cfg_write(CFG_RATIO, 16'd0);
    for (int i = 0; i < 8; i++) begin
      w = '{(i[0] ? 16'sh7fff : -16'sh8000), 12'd0, 10'd0};
      pending_words.push_back(w);
    end
    drain();
    cfg_write(CFG_RATIO, 16'd31);
    cfg_write(CFG_SEND, 16'd0);
    cfg_write(CFG_FB, 16'd0);
    cfg_write(CFG_SPMS, 16'd0);
    cfg_write(CFG_ADJ, 16'd0);
    cfg_write(CFG_SMOOTH, 16'd0);
    cfg_write(CFG_OFF_L, 16'd16383);
    cfg_write(CFG_OFF_R, 16'd16383);
    for (int i = 0; i < 8; i++) pending_words.push_back(rand_word());
    drain();

    // random phases, each with fresh settings; on even phases short offsets keep reads near writes
    for (int ph = 0; ph < 11; ph++) begin
      rand_cfg();
      if (ph % 2 == 0) begin
        cfg_write(CFG_OFF_L, 16'($urandom_range(0, 40)));
        cfg_write(CFG_OFF_R, 16'($urandom_range(0, 40)));
        cfg_write(CFG_SPMS, 16'($urandom_range(0, 600)));
        cfg_write(CFG_RATIO, 16'($urandom_range(1, 3)));
      end
      for (int i = 0; i < 150; i++) begin
        pending_words.push_back(rand_word());
        if (i == 75 && ph == 4) begin
          // sender waits for every expected result
          while (pending_words.size() > 0 || in_valid) @(posedge clk);
          hold_off = 1;
          while (expected_pairs.size() > 0) @(posedge clk);
          hold_off = 0;
        end
      end
      drain();
    end
    $display("covered %0d result words over directed extremes and 11 random settings",
             words_checked);
    $display("ratios 0..31, gains and offsets at both ends, random handshake gaps");
    if (errors == 0) begin
      $display("stereo_glide_delay_line: match");
    end else begin
      $display("stereo_glide_delay_line: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("stereo_glide_delay_line: mismatch");
    $finish;
  end
endmodule
